// ----- hw/rtl/iss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed sequence store package
// Shared widths, operation codes and the command that is broadcast to the
// row of storage cells.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int CNT_W    = 7;
  localparam int FUNC_W   = 2;
  localparam int IDX_W    = $clog2(CAPACITY);

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/iss_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed sequence store request channel
// Valid/ready channel that carries one operation request per transfer.
// ----------------------------------------------------------------------------
interface iss_in_if
  import iss_pkg::*;
();

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);

endinterface
`default_nettype wire

// ----- hw/rtl/iss_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed sequence store result channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface iss_out_if
  import iss_pkg::*;
();

  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] read_value;
  logic [CNT_W-1:0]         count;

  modport source (output valid, output ok, output read_value, output count, input ready);
  modport sink   (input valid, input ok, input read_value, input count, output ready);

endinterface
`default_nettype wire

// ----- hw/rtl/iss_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed sequence store cell
// Holds one entry and takes its neighbour's value when the row shifts.
// ----------------------------------------------------------------------------
module iss_cell
  import iss_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic                     clk,
  input  wire cell_cmd_t                cmd,
  input  wire logic signed [DATA_W-1:0] left_i,
  input  wire logic signed [DATA_W-1:0] right_i,
  output logic signed [DATA_W-1:0]      q_o
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  logic signed [DATA_W-1:0] q_r;
  logic signed [DATA_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (cmd.ins) begin
      if (MY_POS == cmd.pos) begin
        q_nxt = cmd.val;
      end else if (MY_POS > cmd.pos) begin
        q_nxt = left_i;
      end
    end else if (cmd.rem) begin
      if (MY_POS >= cmd.pos) begin
        q_nxt = right_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule
`default_nettype wire

// ----- hw/rtl/indexed_sequence_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed sequence store
// Ordered store of signed 32-bit entries with insert, remove and read by index.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch: func selects insert, remove or read, position is
// the zero-based index and value is the entry to insert. Each request gives
// exactly one result on out_ch: ok, the entry read (minus one for a read out
// of range, zero for other operations) and the entry count afterwards.
// The entries sit in a row of cells that all shift in the cycle of the
// transfer, and the result is registered: it appears on out_ch in the cycle
// after the transfer, and a new request may be taken in every cycle while
// the receiver does not stall.
// A request is taken while the result register is empty or being emptied in
// the same cycle; when the receiver stalls, one result waits and in_ch.ready
// falls until it has gone.
// Reset empties the store and drops any pending result; the entries keep
// their old contents, which are never read before they are written again.
// ----------------------------------------------------------------------------
module indexed_sequence_store
  import iss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  iss_in_if.sink    in_ch,
  iss_out_if.source out_ch
);

  logic signed [DATA_W-1:0] cell_q [CAPACITY];
  cell_cmd_t                cmd;

  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic                     out_valid_r;
  logic                     out_ok_r;
  logic signed [DATA_W-1:0] out_rd_r;
  logic [CNT_W-1:0]         out_cnt_r;

  logic                     accept;
  logic                     is_ins;
  logic                     is_rem;
  logic                     is_rd;
  logic                     full;
  logic                     in_range;
  logic                     ins_ok;
  logic                     rem_ok;
  logic                     rd_ok;
  logic                     res_ok;
  logic signed [DATA_W-1:0] rd_sel;
  logic signed [DATA_W-1:0] res_rd;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign is_ins   = in_ch.func == OP_INSERT;
  assign is_rem   = in_ch.func == OP_REMOVE;
  assign is_rd    = in_ch.func == OP_READ;
  assign full     = cnt_r == CNT_W'(CAPACITY);
  assign in_range = in_ch.position < cnt_r;
  assign ins_ok   = is_ins && (in_ch.position <= cnt_r) && !full;
  assign rem_ok   = is_rem && in_range;
  assign rd_ok    = is_rd && in_range;
  assign res_ok   = ins_ok || rem_ok || rd_ok;

  assign cmd.ins = accept && ins_ok;
  assign cmd.rem = accept && rem_ok;
  assign cmd.pos = in_ch.position;
  assign cmd.val = in_ch.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = cell_q[i];
    end else begin : g_mid_l
      assign left_v = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_q[i];
    end else begin : g_mid_r
      assign right_v = cell_q[i+1];
    end
    iss_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .left_i  (left_v),
      .right_i (right_v),
      .q_o     (cell_q[i])
    );
  end

  assign rd_sel = cell_q[in_ch.position[IDX_W-1:0]];

  always_comb begin
    res_rd = '0;
    if (rd_ok) begin
      res_rd = rd_sel;
    end else if (is_rd) begin
      res_rd = -DATA_W'(1);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.rem) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r  <= res_ok;
      out_rd_r  <= res_rd;
      out_cnt_r <= cnt_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = out_ok_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.count      = out_cnt_r;

endmodule
`default_nettype wire
